@@ src/clnw_pkg.sv @@
// ----------------------------------------------------------------------------
// clnw_pkg
// Types and constants shared by the character display nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

  localparam int unsigned ENTRY_W = 9;

  // Configuration register indexes
  localparam logic [1:0] CFG_REALTIME_MODE  = 2'd0;
  localparam logic [1:0] CFG_ENABLE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_HIGH_SETTLE    = 2'd2;
  localparam logic [1:0] CFG_LOW_SETTLE     = 2'd3;

  // Reset values of the configuration registers
  localparam logic       RST_REALTIME_MODE  = 1'b1;
  localparam logic [7:0] RST_ENABLE_WIDTH   = 8'd1;
  localparam logic [9:0] RST_HIGH_SETTLE    = 10'd1;
  localparam logic [9:0] RST_LOW_SETTLE     = 10'd34;

  // Opcodes
  localparam logic OP_SEND  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_PHASE   = 2'd0;
  localparam logic [1:0] ST_QUEUED  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Steps of one nibble transfer
  localparam logic [1:0] STEP_SETUP  = 2'd0;
  localparam logic [1:0] STEP_PULSE  = 2'd1;
  localparam logic [1:0] STEP_SETTLE = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_value;
    logic       is_data;
  } clnw_req_t;

  typedef struct packed {
    logic       register_select;
    logic       enable_level;
    logic [3:0] data_nibble;
    logic [9:0] hold_us;
    logic [1:0] status;
    logic       last;
  } clnw_res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } clnw_qcmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } clnw_qstat_t;

endpackage

@@ src/clnw_ram.sv @@
// ----------------------------------------------------------------------------
// clnw_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module clnw_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 9,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/clnw_queue.sv @@
// ----------------------------------------------------------------------------
// clnw_queue
// FIFO of queued requests: head, tail and fill count around one RAM.
// ----------------------------------------------------------------------------
module clnw_queue #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  clnw_pkg::clnw_qcmd_t          cmd_i,
  input  logic [clnw_pkg::ENTRY_W-1:0]  wdata_i,
  output clnw_pkg::clnw_qstat_t         stat_o,
  output logic [clnw_pkg::ENTRY_W-1:0]  rdata_o
);
  import clnw_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.push) begin
      tail_d  = (tail_q == PTR_MAX) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      head_d  = (head_q == PTR_MAX) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_FULL);

  clnw_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W),
    .AW    (PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail_q),
    .wdata_i (wdata_i),
    .re_i    (cmd_i.pop),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

endmodule

@@ src/clnw_seq.sv @@
// ----------------------------------------------------------------------------
// clnw_seq
// Request decode, configuration registers and the pin phase sequencer.
// ----------------------------------------------------------------------------
module clnw_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  clnw_pkg::clnw_req_t           req_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [9:0]                    cfg_wdata_i,
  output clnw_pkg::clnw_qcmd_t          qcmd_o,
  output logic [clnw_pkg::ENTRY_W-1:0]  qwdata_o,
  input  clnw_pkg::clnw_qstat_t         qstat_i,
  input  logic [clnw_pkg::ENTRY_W-1:0]  qrdata_i,
  output logic                          res_valid_o,
  output clnw_pkg::clnw_res_t           res_o
);
  import clnw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic       realtime_q;
  logic [7:0] enable_width_q;
  logic [9:0] high_settle_q;
  logic [9:0] low_settle_q;

  logic [7:0] byte_q, byte_d;
  logic       flag_q, flag_d;
  logic       low_nib_q, low_nib_d;
  logic [1:0] step_q, step_d;
  logic       res_valid_q, res_valid_d;
  clnw_res_t  res_q, res_d;
  logic       accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign qwdata_o = {req_i.is_data, req_i.byte_value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      realtime_q     <= RST_REALTIME_MODE;
      enable_width_q <= RST_ENABLE_WIDTH;
      high_settle_q  <= RST_HIGH_SETTLE;
      low_settle_q   <= RST_LOW_SETTLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REALTIME_MODE: realtime_q     <= cfg_wdata_i[0];
        CFG_ENABLE_WIDTH:  enable_width_q <= cfg_wdata_i[7:0];
        CFG_HIGH_SETTLE:   high_settle_q  <= cfg_wdata_i;
        CFG_LOW_SETTLE:    low_settle_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    flag_d      = flag_q;
    low_nib_d   = low_nib_q;
    step_d      = step_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    qcmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.opcode == OP_SEND) begin
            if (realtime_q) begin
              byte_d    = req_i.byte_value;
              flag_d    = req_i.is_data;
              low_nib_d = 1'b0;
              step_d    = STEP_SETUP;
              state_d   = S_EMIT;
            end else if (qstat_i.full) begin
              res_valid_d = 1'b1;
              res_d.status = ST_DROPPED;
              res_d.last   = 1'b1;
            end else begin
              qcmd_o.push  = 1'b1;
              res_valid_d  = 1'b1;
              res_d.status = ST_QUEUED;
              res_d.last   = 1'b1;
            end
          end else if (qstat_i.empty) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_EMPTY;
            res_d.last   = 1'b1;
          end else begin
            qcmd_o.pop = 1'b1;
            state_d    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // queue entry arrives in the cycle after the pop
        byte_d    = qrdata_i[7:0];
        flag_d    = qrdata_i[8];
        low_nib_d = 1'b0;
        step_d    = STEP_SETUP;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        res_valid_d           = 1'b1;
        res_d.register_select = flag_q;
        res_d.enable_level    = (step_q == STEP_PULSE);
        res_d.data_nibble     = low_nib_q ? byte_q[3:0] : byte_q[7:4];
        res_d.status          = ST_PHASE;
        if (step_q == STEP_SETTLE) begin
          res_d.hold_us = low_nib_q ? low_settle_q : high_settle_q;
          step_d        = STEP_SETUP;
          low_nib_d     = 1'b1;
          if (low_nib_q) begin
            res_d.last = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          res_d.hold_us = {2'b00, enable_width_q};
          step_d        = step_q + 2'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      low_nib_q   <= 1'b0;
      step_q      <= STEP_SETUP;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      low_nib_q   <= low_nib_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    flag_q <= flag_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ src/char_lcd_nibble_writer_with_queue_unit.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_with_queue_unit
// Character display writer for a 4-bit bus with a deferred request queue.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------
//  request   | start_i / busy_o   | req_i (opcode, byte, flag)
//  result    | res_valid_o strobe | res_o (pins, hold, status)
//  config    | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// A send in real-time mode keeps busy_o high while it yields one pin phase per
// cycle; a drain of a held entry first passes a fetch state for the queue RAM
// read. Queued, dropped and empty status results appear the cycle after the
// request and do not raise busy_o. Every result is shown for one cycle only.
// After reset the queue is empty and the registers hold their reset values.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_with_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  clnw_pkg::clnw_req_t  req_i,
  output logic                 busy_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [9:0]           cfg_wdata_i,
  output logic                 res_valid_o,
  output clnw_pkg::clnw_res_t  res_o
);
  import clnw_pkg::*;

  clnw_qcmd_t         qcmd;
  clnw_qstat_t        qstat;
  logic [ENTRY_W-1:0] qwdata;
  logic [ENTRY_W-1:0] qrdata;

  clnw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .qcmd_o      (qcmd),
    .qwdata_o    (qwdata),
    .qstat_i     (qstat),
    .qrdata_i    (qrdata),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  clnw_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (qcmd),
    .wdata_i (qwdata),
    .stat_o  (qstat),
    .rdata_o (qrdata)
  );

endmodule
